// File: design/phbm_pkg.sv
// package: shared constants, register indexes and item codes of the peak hold bar meter
package phbm_pkg;

  // fixed field widths
  localparam int unsigned LevelBits   = 10;
  localparam int unsigned WinBits     = 8;
  localparam int unsigned TimeoutBits = 10;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 10;

  // parameter defaults
  localparam int unsigned SampleBitsDef = 10;
  localparam int unsigned LampCountDef  = 10;
  localparam int unsigned LevelStepDef  = 10;

  // register reset values
  localparam logic [WinBits-1:0]     WindowLengthRst   = WinBits'(50);
  localparam logic [LevelBits-1:0]   FirstThresholdRst = LevelBits'(6);
  localparam logic [TimeoutBits-1:0] IdleTimeoutRst    = TimeoutBits'(1000);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWindowLength   = 2'd0,
    CfgFirstThreshold = 2'd1,
    CfgIdleTimeout    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CmdSample   = 1'b0,
    CmdActivity = 1'b1
  } cmd_e;

endpackage

// File: design/peak_hold_bar_meter_core.sv
// top level: peak hold level meter with active-low lamp bar and activity flag
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: sample, tuser: cmd
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: bar_pattern, held_level; tuser: active
// cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// one item a cycle sustained while m_axis_tready holds; an accepted item is registered in the
// input register and then in the result register, from which its result is taken
// every accepted item gives exactly one result item
// rst_ni clears all meter state to zero and loads the register defaults
// a stalled result holds in the result register while one more item waits
// in the input register; the input stalls only when both are full
// cfg writes are always taken, as cfg_ready_o is tied high
module peak_hold_bar_meter_core
  import phbm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned LAMP_COUNT  = LampCountDef,
  parameter int unsigned LEVEL_STEP  = LevelStepDef,
  localparam int unsigned SDataW = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned MDataW = ((LAMP_COUNT + LevelBits + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SDataW-1:0]      s_axis_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic                   s_axis_tuser,   // [0] cmd
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [MDataW-1:0]      m_axis_tdata,   // bar_pattern low, then held_level, rest zero
  output logic                   m_axis_tuser,   // [0] active
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // comparator width covers both the level and the top lamp threshold
  localparam int unsigned ThrBits = $clog2(LAMP_COUNT * LEVEL_STEP + 1);
  localparam int unsigned CmpBits = (ThrBits > LevelBits) ? ThrBits : LevelBits;

  // configuration registers
  logic [WinBits-1:0]     win_len_q;
  logic [LevelBits-1:0]   first_thr_q;
  logic [TimeoutBits-1:0] idle_tmo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WindowLengthRst;
      first_thr_q <= FirstThresholdRst;
      idle_tmo_q  <= IdleTimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgWindowLength:   win_len_q   <= cfg_data_i[WinBits-1:0];
        CfgFirstThreshold: first_thr_q <= cfg_data_i[LevelBits-1:0];
        CfgIdleTimeout:    idle_tmo_q  <= cfg_data_i[TimeoutBits-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input register
  logic                 s1_valid_q;
  cmd_e                 s1_cmd_q;
  logic [LevelBits-1:0] s1_sample_q;
  logic                 s1_fire;
  logic                 s_fire;

  // result register
  logic                 out_valid_q;
  logic [LAMP_COUNT-1:0] bar_q;
  logic [LevelBits-1:0] level_out_q;
  logic                 active_out_q;

  // item leaves the input register when the result register is free or draining
  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // sample is cut or zero-extended to the level width, as the meter works on 10-bit levels
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_cmd_q    <= cmd_e'(s_axis_tuser);
      s1_sample_q <= LevelBits'(s_axis_tdata[SAMPLE_BITS-1:0]);
    end
  end

  // meter state
  logic [WinBits-1:0]     win_cnt_q, win_cnt_d;
  logic [LevelBits-1:0]   peak_q, peak_d;
  logic [LevelBits-1:0]   hold_q, hold_d;
  logic [TimeoutBits-1:0] idle_cnt_q, idle_cnt_d;
  logic                   active_q, active_d;

  logic [WinBits:0]       win_inc;
  logic [TimeoutBits:0]   idle_inc;
  logic [LevelBits-1:0]   peak_max;

  always_comb begin
    win_inc    = {1'b0, win_cnt_q} + 1'b1;
    idle_inc   = {1'b0, idle_cnt_q} + 1'b1;
    peak_max   = (s1_sample_q > peak_q) ? s1_sample_q : peak_q;
    win_cnt_d  = win_cnt_q;
    peak_d     = peak_q;
    hold_d     = hold_q;
    idle_cnt_d = idle_cnt_q;
    active_d   = active_q;
    case (s1_cmd_q)
      CmdSample: begin
        // window end: at or above, so a length of zero acts as one
        if (win_inc >= {1'b0, win_len_q}) begin
          hold_d    = peak_max;
          peak_d    = '0;
          win_cnt_d = '0;
        end else begin
          peak_d    = peak_max;
          win_cnt_d = win_inc[WinBits-1:0];
        end
        if (idle_inc >= {1'b0, idle_tmo_q}) begin
          active_d   = 1'b0;
          idle_cnt_d = '0;
        end else begin
          idle_cnt_d = idle_inc[TimeoutBits-1:0];
        end
      end
      CmdActivity: begin
        idle_cnt_d = '0;
        active_d   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt_q  <= '0;
      peak_q     <= '0;
      hold_q     <= '0;
      idle_cnt_q <= '0;
      active_q   <= 1'b0;
    end else if (s1_fire) begin
      win_cnt_q  <= win_cnt_d;
      peak_q     <= peak_d;
      hold_q     <= hold_d;
      idle_cnt_q <= idle_cnt_d;
      active_q   <= active_d;
    end
  end

  // thermometer decode of the new held level, active low
  // lamp k lights at or above k steps; lamp one also at the first threshold
  logic [LAMP_COUNT-1:0] bar_d;
  always_comb begin
    for (int k = 0; k < LAMP_COUNT; k++) begin
      bar_d[k] = !(CmpBits'(hold_d) >= CmpBits'((k + 1) * LEVEL_STEP));
    end
    if (hold_d >= first_thr_q) begin
      bar_d[0] = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      bar_q        <= bar_d;
      level_out_q  <= hold_d;
      active_out_q <= active_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = MDataW'({level_out_q, bar_q});
  assign m_axis_tuser  = active_out_q;

endmodule

// File: design/phbm_checker.sv
// checker: port-level assertions for the peak hold bar meter, bound to the top level
module phbm_checker
  import phbm_pkg::*;
#(
  parameter int unsigned MDataW     = 24,
  parameter int unsigned LAMP_COUNT = LampCountDef
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  logic [LAMP_COUNT-1:0] lit_mask;
  assign lit_mask = ~m_axis_tdata[LAMP_COUNT-1:0];

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  // input only stalls while a result is waiting
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // an accepted item passes the input register and reaches the output when the sink is then ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted item did not reach output");

  // lit lamps form a thermometer from lamp one upward
  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((lit_mask & (lit_mask + 1'b1)) == '0))
    else $error("bar pattern is not a thermometer");

endmodule

bind peak_hold_bar_meter_core phbm_checker #(
  .MDataW    (MDataW),
  .LAMP_COUNT(LAMP_COUNT)
) u_phbm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
